// File: design/b64e_pkg.sv
// Shared types, codes and the alphabet mapping for the base64 stream encoder.
// No dependencies; every other design file except b64e_if refers to it by scoped names.
package b64e_pkg;

   localparam logic [7:0] CHAR_PAD = 8'h3D;   // '='

   // bytes already taken in the current 3-byte group
   typedef enum logic [1:0] {
      PH_EMPTY = 2'd0,
      PH_ONE   = 2'd1,
      PH_TWO   = 2'd2
   } phase_type;

   // one classified input byte: up to four characters to emit
   typedef struct packed {
      logic [3:0][5:0] code;      // 6-bit codes, slot 0 first
      logic [3:0]      pad;       // slot emits '=' instead of a code
      logic [1:0]      count_m1;  // number of slots minus one
      logic            last;      // message ends with the final slot
   } job_type;

   typedef struct packed {
      logic not_full;
      logic not_empty;
   } queue_status_type;

   // 6-bit code to ASCII; url selects '-' '_' in place of '+' '/'
   function automatic logic [7:0] map_code(input logic [5:0] code, input logic url);
      logic [7:0] c;
      c = {2'b00, code};
      case (code) inside
         [6'd0:6'd25]:  map_code = c + 8'd65;     // 'A'..
         [6'd26:6'd51]: map_code = c + 8'd71;     // 'a'..
         [6'd52:6'd61]: map_code = c - 8'd4;      // '0'..
         6'd62:         map_code = url ? 8'h2D : 8'h2B;
         default:       map_code = url ? 8'h5F : 8'h2F;
      endcase
   endfunction

endpackage

// File: design/b64e_if.sv
// Handshake channels of the base64 stream encoder: raw bytes in, characters out.
// Stand-alone; no package needed.
interface b64e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface b64e_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       end_of_text;

   modport source (output valid, out_char, end_of_text, input ready);
   modport sink   (input valid, out_char, end_of_text, output ready);
endinterface

// File: design/base64_stream_encoder.sv
// Top level of the base64 stream encoder: front end, job queue and back end.
// Depends on b64e_pkg, b64e_if, b64e_front, b64e_queue and b64e_back.
//
//   channel   direction  payload                      handshake
//   req_ch    in         data_byte[7:0], last_byte    valid/ready
//   rsp_ch    out        out_char[7:0], end_of_text   valid/ready
//   csr_*     in         csr_wr_data[1:0] (alphabet)  csr_wr_en, no wait
//
// One character leaves per cycle from the back end's output register while rsp_ch is
//   ready; a byte yields one or two characters (four per three bytes), a final byte up to four.
// A byte is taken whenever the job queue has room; the queue lets the front
//   keep accepting while the back end is still emitting earlier characters.
// Reset (synchronous) clears group phase, carry bits, queue and output valid,
//   and sets the alphabet to standard with padding.
// A stall on rsp_ch holds the output character; input stalls only once the
//   queue is full.
module base64_stream_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   b64e_req_if.sink   req_ch,
   b64e_rsp_if.source rsp_ch,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data
);

   // alphabet_mode: bit 0 or 1 selects url-safe, bit 1 drops padding
   logic [1:0] mode_ff;

   b64e_pkg::queue_status_type q_status;
   b64e_pkg::job_type          push_job, pop_job;
   logic                       push, pop;

   always_ff @(posedge clock) begin
      if (reset)          mode_ff <= 2'd0;
      else if (csr_wr_en) mode_ff <= csr_wr_data;
   end

   // classify each byte into a job of one to four characters
   b64e_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .mode     (mode_ff),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .status   (q_status)
   );

   // emit characters of each job in slot order
   b64e_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .pop_job  (pop_job),
      .pop      (pop),
      .mode     (mode_ff),
      .rsp_ch   (rsp_ch)
   );

endmodule

// File: design/b64e_front.sv
// Front end: accepts bytes, tracks group phase and carry bits, builds one job per byte.
// Uses b64e_pkg and the request channel interface.
module b64e_front (
   input  logic                      clock,
   input  logic                      reset,
   b64e_req_if.sink                  req_ch,
   input  logic [1:0]                mode,
   input  b64e_pkg::queue_status_type q_status,
   output logic                      push,
   output b64e_pkg::job_type         push_job
);

   b64e_pkg::phase_type phase_ff, phase_in;
   logic [3:0]          carry_ff, carry_in;
   logic                accept;
   logic                pad_en;
   logic [7:0]          b;

   assign req_ch.ready = q_status.not_full;
   assign accept       = req_ch.valid & q_status.not_full;
   assign push         = accept;
   assign pad_en       = ~mode[1];
   assign b            = req_ch.data_byte;

   always_comb begin
      push_job      = '0;
      push_job.last = req_ch.last_byte;
      phase_in      = phase_ff;
      carry_in      = carry_ff;
      case (phase_ff)
         b64e_pkg::PH_EMPTY: begin
            push_job.code[0] = b[7:2];
            phase_in         = b64e_pkg::PH_ONE;
            carry_in         = {2'b00, b[1:0]};
            if (req_ch.last_byte) begin
               push_job.code[1] = {b[1:0], 4'b0000};
               if (pad_en) begin
                  push_job.pad      = 4'b1100;
                  push_job.count_m1 = 2'd3;
               end else begin
                  push_job.count_m1 = 2'd1;
               end
            end
         end
         b64e_pkg::PH_ONE: begin
            push_job.code[0] = {carry_ff[1:0], b[7:4]};
            phase_in         = b64e_pkg::PH_TWO;
            carry_in         = b[3:0];
            if (req_ch.last_byte) begin
               push_job.code[1] = {b[3:0], 2'b00};
               if (pad_en) begin
                  push_job.pad      = 4'b0100;
                  push_job.count_m1 = 2'd2;
               end else begin
                  push_job.count_m1 = 2'd1;
               end
            end
         end
         default: begin
            push_job.code[0]  = {carry_ff, b[7:6]};
            push_job.code[1]  = b[5:0];
            push_job.count_m1 = 2'd1;
            phase_in          = b64e_pkg::PH_EMPTY;
            carry_in          = 4'd0;
         end
      endcase
      if (req_ch.last_byte) begin
         phase_in = b64e_pkg::PH_EMPTY;
         carry_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= b64e_pkg::PH_EMPTY;
         carry_ff <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule

// File: design/b64e_queue.sv
// Short job queue between front and back end, register based.
// Uses b64e_pkg for the job and status types.
module b64e_queue #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  b64e_pkg::job_type          push_job,
   input  logic                       pop,
   output b64e_pkg::job_type          pop_job,
   output b64e_pkg::queue_status_type status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   b64e_pkg::job_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;

   assign status.not_full  = (count_ff != FULL_CNT);
   assign status.not_empty = (count_ff != '0);
   assign pop_job          = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

// File: design/b64e_back.sv
// Back end: walks the slots of each job and emits one character per cycle while rsp_ch is ready.
// Uses b64e_pkg and the result channel interface.
module b64e_back (
   input  logic                       clock,
   input  logic                       reset,
   input  b64e_pkg::queue_status_type q_status,
   input  b64e_pkg::job_type          pop_job,
   output logic                       pop,
   input  logic [1:0]                 mode,
   b64e_rsp_if.source                 rsp_ch
);

   b64e_pkg::job_type cur_ff;
   logic              cur_valid_ff;
   logic [1:0]        idx_ff;
   logic              out_valid_ff;
   logic [7:0]        char_ff, char_in;
   logic              eot_ff;
   logic              adv, issue, last_slot, cur_free;

   assign adv       = ~out_valid_ff | rsp_ch.ready;
   assign issue     = adv & cur_valid_ff;
   assign last_slot = (idx_ff == cur_ff.count_m1);
   assign cur_free  = ~cur_valid_ff | (issue & last_slot);
   assign pop       = cur_free & q_status.not_empty;

   always_comb begin
      if (cur_ff.pad[idx_ff]) char_in = b64e_pkg::CHAR_PAD;
      else                    char_in = b64e_pkg::map_code(cur_ff.code[idx_ff], |mode);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            cur_valid_ff <= 1'b1;
            idx_ff       <= 2'd0;
         end else if (cur_free) begin
            cur_valid_ff <= 1'b0;
         end else if (issue) begin
            idx_ff <= idx_ff + 2'd1;
         end
         if (adv) out_valid_ff <= cur_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) cur_ff <= pop_job;
      if (issue) begin
         char_ff <= char_in;
         eot_ff  <= cur_ff.last & last_slot;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.out_char    = char_ff;
   assign rsp_ch.end_of_text = eot_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (idx_ff <= cur_ff.count_m1))
      else $error("slot index beyond job length");

   a_pop_only_when_free: assert property (@(posedge clock) disable iff (reset)
      pop |-> (cur_free && q_status.not_empty))
      else $error("job taken while current job still busy");

   a_job_continues: assert property (@(posedge clock) disable iff (reset)
      (issue && !last_slot) |=> (cur_valid_ff && idx_ff == $past(idx_ff) + 2'd1))
      else $error("job dropped before its last slot");

endmodule
